// ===== hw/rtl/ett_pkg.sv =====
// Shared types and constants for the expiring token table.
`default_nettype none

package ett_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int EXP_W       = 33;

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam logic REG_TTL   = 1'b0;
  localparam logic [31:0] TTL_RESET = 32'd5;

  // Operation codes
  localparam logic [1:0] FUNC_GEN   = 2'd0;
  localparam logic [1:0] FUNC_RENEW = 2'd1;
  localparam logic [1:0] FUNC_COUNT = 2'd2;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [EXP_W-1:0]    exp_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] token_key;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [4:0] live_count;
    logic       status;
  } out_t;

  // One table entry as it travels down the row of cells
  typedef struct packed {
    key_t key;
    exp_t expiry;
  } entry_t;

  // Row control broadcast to every cell
  typedef struct packed {
    logic pop;
    logic push;
    cnt_t len;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ett_cell.sv =====
// One table slot: holds an entry, takes its neighbor's entry or the tail bus.
`default_nettype none

module ett_cell (
  input  wire logic            clk,
  input  wire ett_pkg::cnt_t   idx,
  input  wire ett_pkg::ctrl_t  ctrl,
  input  wire ett_pkg::entry_t nbr_in,
  input  wire ett_pkg::entry_t tail_in,
  output ett_pkg::entry_t      ent_out
);

  ett_pkg::entry_t ent_r;
  ett_pkg::entry_t ent_nxt;
  ett_pkg::cnt_t   tail_pos;
  logic            shift;
  logic            load;

  // Decide whether this slot advances, loads the tail entry or holds
  always_comb begin
    tail_pos = ctrl.pop ? (ctrl.len - ett_pkg::cnt_t'(1)) : ctrl.len;
    shift    = ctrl.pop && ((idx + ett_pkg::cnt_t'(1)) < ctrl.len);
    load     = ctrl.push && (idx == tail_pos);
    ent_nxt  = ent_r;
    if (load) begin
      ent_nxt = tail_in;
    end else if (shift) begin
      ent_nxt = nbr_in;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_out = ent_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ett_chain.sv =====
// Row of table cells, head at slot zero, entries move toward the head.
`default_nettype none

module ett_chain (
  input  wire logic            clk,
  input  wire ett_pkg::ctrl_t  ctrl,
  input  wire ett_pkg::entry_t tail_in,
  output ett_pkg::entry_t      head_out
);

  ett_pkg::entry_t ents [ett_pkg::TABLE_DEPTH];

  // Link each cell to the one behind it; the last cell sees itself
  for (genvar g = 0; g < ett_pkg::TABLE_DEPTH; g++) begin : g_cell
    ett_pkg::entry_t nbr;
    if (g == ett_pkg::TABLE_DEPTH - 1) begin : g_last
      assign nbr = ents[g];
    end else begin : g_mid
      assign nbr = ents[g+1];
    end
    ett_cell u_cell (
      .clk     (clk),
      .idx     (ett_pkg::cnt_t'(g)),
      .ctrl    (ctrl),
      .nbr_in  (nbr),
      .tail_in (tail_in),
      .ent_out (ents[g])
    );
  end

  assign head_out = ents[0];

endmodule

`default_nettype wire

// ===== hw/rtl/expiring_token_table_top.sv =====
// Top level of the expiring token table: sequencer, ttl register and result register.
`default_nettype none

// The table is a row of TABLE_DEPTH cells kept as a queue in insertion order.
// Renew and count pop each of the n stored entries off the head once, one per
// cycle, and push it back at the tail (refreshed if renew finds it the first live
// match, or dropped when count finds it expired); generate writes the tail slot
// directly, and an unused code changes nothing. One item is in work at a time;
// a finished result waits in the output register while the next item is taken.
// The ttl register is written through the APB port at byte address 0.
module expiring_token_table_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ett_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output ett_pkg::out_t                      out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ett_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]      state_r, state_nxt;
  ett_pkg::cnt_t   len_r, len_nxt;
  ett_pkg::cnt_t   n_r, n_nxt;
  ett_pkg::cnt_t   step_r, step_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     ttl_r;
  logic [1:0]      func_r, func_nxt;
  ett_pkg::key_t   key_r, key_nxt;
  ett_pkg::exp_t   now_r, now_nxt;
  ett_pkg::exp_t   fresh_r, fresh_nxt;
  ett_pkg::out_t   res_r, res_nxt;
  ett_pkg::out_t   out_r, out_nxt;
  ett_pkg::ctrl_t  ctrl;
  ett_pkg::entry_t tail;
  ett_pkg::entry_t head;
  logic            live;

  ett_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .tail_in  (tail),
    .head_out (head)
  );

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ett_pkg::REG_TTL) ? ttl_r : 32'd0;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign live      = head.expiry > now_r;

  // Sequence one item through the row
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    n_nxt         = n_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    fresh_nxt     = fresh_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ctrl.pop      = 1'b0;
    ctrl.push     = 1'b0;
    ctrl.len      = len_r;
    tail          = head;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_data.func;
          key_nxt   = ett_pkg::key_t'(in_data.token_key);
          now_nxt   = {1'b0, in_data.now};
          fresh_nxt = {1'b0, in_data.now} + {1'b0, ttl_r};
          n_nxt     = len_r;
          step_nxt  = '0;
          found_nxt = 1'b0;
          res_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        case (func_r)
          ett_pkg::FUNC_GEN: begin
            // Append at the tail, or flag a full table
            if (len_r == ett_pkg::cnt_t'(ett_pkg::TABLE_DEPTH)) begin
              res_nxt.status = 1'b1;
            end else begin
              ctrl.push   = 1'b1;
              tail.key    = key_r;
              tail.expiry = fresh_r;
              len_nxt     = len_r + ett_pkg::cnt_t'(1);
            end
            state_nxt = ST_DONE;
          end
          ett_pkg::FUNC_RENEW: begin
            // Rotate every entry once, refresh the first live match
            if (step_r == n_r) begin
              state_nxt = ST_DONE;
            end else begin
              ctrl.pop  = 1'b1;
              ctrl.push = 1'b1;
              if (!found_r && live && (head.key == key_r)) begin
                tail.expiry = fresh_r;
                found_nxt   = 1'b1;
              end
              step_nxt = step_r + ett_pkg::cnt_t'(1);
            end
          end
          ett_pkg::FUNC_COUNT: begin
            // Rotate every entry once, drop the expired ones
            if (step_r == n_r) begin
              res_nxt.live_count = 5'(len_r);
              state_nxt          = ST_DONE;
            end else begin
              ctrl.pop  = 1'b1;
              ctrl.push = live;
              if (!live) begin
                len_nxt = len_r - ett_pkg::cnt_t'(1);
              end
              step_nxt = step_r + ett_pkg::cnt_t'(1);
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
      ttl_r       <= ett_pkg::TTL_RESET;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && pready && (paddr[2] == ett_pkg::REG_TTL)) begin
        ttl_r <= pwdata;
      end
    end
  end

  // Item payload and working registers
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    step_r  <= step_nxt;
    found_r <= found_nxt;
    func_r  <= func_nxt;
    key_r   <= key_nxt;
    now_r   <= now_nxt;
    fresh_r <= fresh_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ett_checker.sv =====
// Port-level checks for the expiring token table, bound to the top level.
`default_nettype none

module ett_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire ett_pkg::out_t                  out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Take one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  // A dropped generate reports no live count
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.live_count == 5'd0)
    else $error("drop flag with nonzero count");

  // Never count more entries than the table holds
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_data.live_count) <= ett_pkg::TABLE_DEPTH)
    else $error("live count above table depth");

endmodule

bind expiring_token_table_top ett_checker u_ett_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the expiring token table: directed and random traffic against a table predictor.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [ett_pkg::CFG_ADDR_W-1:0] TTL_ADDR =
    ett_pkg::CFG_ADDR_W'(4 * ett_pkg::REG_TTL);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = ett_pkg::TABLE_DEPTH + 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ett_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ett_pkg::out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ett_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predicted table state
  logic [31:0] model_ttl = ett_pkg::TTL_RESET;
  ett_pkg::key_t model_key [ett_pkg::TABLE_DEPTH];
  ett_pkg::exp_t model_expiry [ett_pkg::TABLE_DEPTH];
  int model_fill = 0;

  ett_pkg::in_t pending_ops [$];
  ett_pkg::out_t expected_results [$];
  logic [31:0] cur_now = '0;
  bit in_taken = 1'b0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  expiring_token_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // Apply one operation to the predicted table and return its result
  function automatic ett_pkg::out_t predict_token_op(ett_pkg::in_t op);
    ett_pkg::exp_t fresh;
    ett_pkg::exp_t now_x;
    ett_pkg::out_t res;
    int kept;
    bit found;
    fresh = {1'b0, op.now} + {1'b0, model_ttl};
    now_x = {1'b0, op.now};
    res = '0;
    found = 1'b0;
    kept = 0;
    case (op.func)
      ett_pkg::FUNC_GEN: begin
        if (model_fill >= ett_pkg::TABLE_DEPTH) begin
          res.status = 1'b1;
        end else begin
          model_key[model_fill] = op.token_key[ett_pkg::KEY_BITS-1:0];
          model_expiry[model_fill] = fresh;
          model_fill++;
        end
      end
      ett_pkg::FUNC_RENEW: begin
        for (int i = 0; i < model_fill; i++) begin
          if (!found && model_key[i] == op.token_key[ett_pkg::KEY_BITS-1:0] &&
              model_expiry[i] > now_x) begin
            model_expiry[i] = fresh;
            found = 1'b1;
          end
        end
      end
      ett_pkg::FUNC_COUNT: begin
        for (int i = 0; i < model_fill; i++) begin
          if (model_expiry[i] > now_x) begin
            model_key[kept] = model_key[i];
            model_expiry[kept] = model_expiry[i];
            kept++;
          end
        end
        model_fill = kept;
        res.live_count = 5'(kept);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Gap length: mostly none or short, a few long, none at all in a burst
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_op(logic [1:0] func, logic [31:0] key, logic [31:0] now);
    ett_pkg::in_t op;
    op.func = func;
    op.token_key = key;
    op.now = now;
    pending_ops = {pending_ops, op};
  endtask

  // Random operation over a small key pool, time creeping forward with rare jumps
  task automatic push_random_op();
    int r;
    logic [1:0] func;
    logic [31:0] key;
    longint unsigned t;
    r = $urandom_range(0, 99);
    if (r < 45) func = ett_pkg::FUNC_GEN;
    else if (r < 75) func = ett_pkg::FUNC_RENEW;
    else func = ett_pkg::FUNC_COUNT;
    key = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7);
    if ($urandom_range(0, 15) == 0) t = longint'(cur_now) + $urandom_range(0, model_ttl);
    else t = longint'(cur_now) + $urandom_range(0, 2);
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    cur_now = t[31:0];
    push_op(func, key, cur_now);
  endtask

  task automatic write_ttl(logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TTL_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Read ttl back and compare against the predicted register
  task automatic check_ttl();
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= TTL_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== model_ttl) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ttl readback: expected %h, got %h", model_ttl, got);
    end
  endtask

  // Hold until every item is taken and every result has come, then let the block settle
  task automatic wait_idle();
    @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(logic [31:0] ttl, int count);
    write_ttl(ttl);
    check_ttl();
    for (int i = 0; i < count; i++) push_random_op();
    wait_idle();
  endtask

  // Drive items from the pending queue with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_ops.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_ops.pop_front();
        if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
        in_gap = pick_gap(in_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
      out_stall = pick_gap(out_burst);
    end
  end

  // Check results, predict accepted items, track ttl writes
  always @(posedge clk) begin
    cycle_count++;
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: live_count %0d status %0d",
                     out_data.live_count, out_data.status);
        end else begin
          ett_pkg::out_t want;
          want = expected_results.pop_front();
          if (out_data.live_count !== want.live_count || out_data.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected live_count %0d status %0d, got %0d %0d",
                       want.live_count, want.status, out_data.live_count, out_data.status);
          end
        end
      end
      if (in_taken) expected_results = {expected_results, predict_token_op(in_data)};
      if (psel && penable && pwrite && pready && paddr == TTL_ADDR) model_ttl = pwdata;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("expiring_token_table_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_ttl();

    // Directed: empty table, key extremes, unused code, fill, full count
    push_op(ett_pkg::FUNC_COUNT, 32'h0, 32'd0);
    push_op(ett_pkg::FUNC_RENEW, 32'h0, 32'd0);
    push_op(ett_pkg::FUNC_GEN, 32'h0, 32'd0);
    push_op(ett_pkg::FUNC_GEN, 32'hFFFF_FFFF, 32'd0);
    push_op(ett_pkg::FUNC_RENEW, 32'hFFFF_FFFF, 32'd1);
    push_op(ett_pkg::FUNC_RENEW, 32'h0000_1234, 32'd1);
    push_op(FUNC_NONE, $urandom, 32'd1);
    push_op(ett_pkg::FUNC_COUNT, 32'h0, 32'd5);
    for (int i = 1; i < ett_pkg::TABLE_DEPTH; i++) push_op(ett_pkg::FUNC_GEN, i, 32'd5);
    push_op(ett_pkg::FUNC_GEN, 32'hA5A5_A5A5, 32'd5);
    push_op(ett_pkg::FUNC_COUNT, $urandom, 32'd5);
    // time steps backwards once
    push_op(ett_pkg::FUNC_RENEW, 32'hFFFF_FFFF, 32'd2);
    wait_idle();

    // Zero lifetime: tokens are born expired
    write_ttl(32'd0);
    check_ttl();
    push_op(ett_pkg::FUNC_COUNT, 32'h0, 32'd11);
    push_op(ett_pkg::FUNC_GEN, 32'd7, 32'd11);
    push_op(ett_pkg::FUNC_RENEW, 32'd7, 32'd11);
    push_op(ett_pkg::FUNC_COUNT, 32'h0, 32'd11);
    wait_idle();
    cur_now = 32'd11;

    run_random_phase(32'd1, 300);
    run_random_phase(32'd5, 400);
    run_random_phase(32'd12, 400);
    run_random_phase($urandom_range(1000, 100000), 400);
    // Top of the time range with the longest lifetime
    if (cur_now < 32'hFFFF_FF00) cur_now = 32'hFFFF_FF00;
    run_random_phase(32'hFFFF_FFFF, 400);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("expiring_token_table_top test passed");
    end else begin
      $display("expiring_token_table_top test failed");
    end
    $finish;
  end

endmodule
